FILE: hw/rtl/stu_pkg.sv
// Shared types, constants and scanning helpers for the source tokenizer.
// Depends on nothing; every other file of the block but stu_char_if uses it by scoped names.
package stu_pkg;

	localparam int LINE_W      = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_RES     = 4;
	localparam logic [LINE_W-1:0] LINE_MAX   = '1;
	localparam logic [LINE_W-1:0] LINE_RESET = 24'd1;

	typedef enum logic [4:0] {
		M_IDLE, M_DOLLAR, M_NAME, M_LT, M_GT, M_TILDE, M_DOT, M_STR, M_ESC,
		M_INT, M_FRAC, M_EXPS, M_EXPSIGN, M_EXPD, M_SLASH, M_LCOM, M_BCOM, M_BSTAR
	} mode_t;

	typedef enum logic [3:0] {
		K_END, K_CHAR, K_NAME, K_KEYWORD, K_STRING, K_NUMBER,
		K_LE, K_GE, K_NE, K_CONC, K_DEBUG, K_WRONG
	} kind_t;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BSL = 8'h5C;

	localparam logic [63:0] KW_TEXT [16] = '{
		"and", "do", "else", "elseif", "end", "function", "if", "local",
		"nil", "not", "or", "repeat", "return", "then", "until", "while"};
	localparam logic [3:0] KW_LEN [16] = '{
		4'd3, 4'd2, 4'd4, 4'd6, 4'd3, 4'd8, 4'd2, 4'd5,
		4'd3, 4'd3, 4'd2, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5};
	localparam logic [63:0] DBG_TEXT [2] = '{"debug", "nodebug"};
	localparam logic [3:0] DBG_LEN [2] = '{4'd5, 4'd7};

	// One result without its line number.
	typedef struct packed {
		logic       is_text;
		logic [7:0] text_byte;
		kind_t      token_kind;
		logic [3:0] keyword_index;
		logic [7:0] char_value;
		logic       debug_on;
		logic       comment_error;
	} rec_t;

	// All results caused by one character.
	typedef struct packed {
		logic [2:0]        cnt;
		logic [LINE_W-1:0] line;
		rec_t [MAX_RES-1:0] rec;
	} group_t;

	typedef struct packed {
		mode_t             mode;
		logic [15:0]       cand;
		logic [3:0]        wlen;
		logic [1:0]        dm;
		logic [7:0]        delim;
		logic [LINE_W-1:0] line;
	} scan_t;

	typedef struct packed {
		scan_t      st;
		logic       again;
		logic [1:0] n;
		rec_t       r0;
		rec_t       r1;
	} step_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	// Byte at position p of a right-aligned string literal of length len.
	function automatic logic [7:0] str_at(input logic [63:0] s, input logic [3:0] len,
			input logic [3:0] p);
		logic [63:0] sh;
		sh = s >> (8 * (32'(len) - 32'(p) - 1));
		return sh[7:0];
	endfunction

	function automatic rec_t mk_text(input logic [7:0] c);
		rec_t r;
		r = '0;
		r.is_text = 1'b1;
		r.text_byte = c;
		r.token_kind = K_END;
		return r;
	endfunction

	function automatic rec_t mk_fin(input kind_t k);
		rec_t r;
		r = '0;
		r.token_kind = k;
		return r;
	endfunction

	function automatic rec_t mk_char(input logic [7:0] c);
		rec_t r;
		r = '0;
		r.token_kind = K_CHAR;
		r.char_value = c;
		return r;
	endfunction

endpackage

FILE: hw/rtl/stu_char_if.sv
// Character input channel of the source tokenizer: valid/ready and one byte.
// Depends on nothing.
interface stu_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;

	modport source(output valid, output ch, input ready);
	modport sink(input valid, input ch, output ready);
endinterface

FILE: hw/rtl/stu_tok_if.sv
// Result channel of the source tokenizer: valid/ready and one result beat.
// Depends on stu_pkg for the line width.
interface stu_tok_if;
	logic                       valid;
	logic                       ready;
	logic                       is_text;
	logic [7:0]                 text_byte;
	logic [3:0]                 token_kind;
	logic [3:0]                 keyword_index;
	logic [7:0]                 char_value;
	logic                       debug_on;
	logic [stu_pkg::LINE_W-1:0] line_number;
	logic                       comment_error;
	logic                       last;

	modport source(output valid, output is_text, output text_byte, output token_kind,
		output keyword_index, output char_value, output debug_on, output line_number,
		output comment_error, output last, input ready);
	modport sink(input valid, input is_text, input text_byte, input token_kind,
		input keyword_index, input char_value, input debug_on, input line_number,
		input comment_error, input last, output ready);
endinterface

FILE: hw/rtl/stu_front.sv
// Front end: takes one character per beat, runs the scanner state machine and
// builds the group of results it causes. Depends on stu_pkg and stu_char_if.
module stu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	stu_char_if.sink                     src,
	input  logic                         first_line_we,
	input  logic [stu_pkg::LINE_W-1:0]   first_line_wdata,
	input  logic                         q_full,
	output logic                         push,
	output stu_pkg::group_t              grp
);

	stu_pkg::scan_t              st_q, st_d;
	logic [stu_pkg::LINE_W-1:0]  first_line_q;

	function automatic stu_pkg::scan_t word_start(input stu_pkg::scan_t s);
		stu_pkg::scan_t o;
		o = s;
		o.cand = '1;
		o.dm = 2'b11;
		o.wlen = '0;
		return o;
	endfunction

	// Narrows the keyword and $-word candidate masks by one more letter.
	function automatic stu_pkg::scan_t word_add(input stu_pkg::scan_t s,
			input logic [7:0] c);
		stu_pkg::scan_t o;
		o = s;
		for (int k = 0; k < 16; k++) begin
			if (!(s.wlen < stu_pkg::KW_LEN[k] &&
					stu_pkg::str_at(stu_pkg::KW_TEXT[k], stu_pkg::KW_LEN[k], s.wlen) == c))
				o.cand[k] = 1'b0;
		end
		for (int k = 0; k < 2; k++) begin
			if (!(s.wlen < stu_pkg::DBG_LEN[k] &&
					stu_pkg::str_at(stu_pkg::DBG_TEXT[k], stu_pkg::DBG_LEN[k], s.wlen) == c))
				o.dm[k] = 1'b0;
		end
		if (s.wlen != 4'd15) o.wlen = s.wlen + 4'd1;
		return o;
	endfunction

	function automatic logic [stu_pkg::LINE_W-1:0] bump(input logic [stu_pkg::LINE_W-1:0] l);
		return (l == stu_pkg::LINE_MAX) ? l : l + 1'b1;
	endfunction

	// One pass of the scanner over the character in the current mode.
	function automatic stu_pkg::step_t handle(input stu_pkg::scan_t s, input logic [7:0] c,
			input logic [stu_pkg::LINE_W-1:0] fl);
		stu_pkg::step_t h;
		stu_pkg::rec_t  rr;
		logic           hit;
		h = '0;
		h.st = s;
		hit = 1'b0;
		case (s.mode)
			stu_pkg::M_IDLE: begin
				if (c == stu_pkg::CH_NL) h.st.line = bump(s.line);
				else if (c == " " || c == stu_pkg::CH_TAB) h.n = 2'd0;
				else if (c == stu_pkg::CH_NUL) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_fin(stu_pkg::K_END); h.st.line = fl;
				end else if (c == "$") begin
					h.st = word_start(s); h.st.mode = stu_pkg::M_DOLLAR;
				end else if (c inside {"<", ">", "~"}) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c);
					h.st.mode = (c == "<") ? stu_pkg::M_LT :
						(c == ">") ? stu_pkg::M_GT : stu_pkg::M_TILDE;
				end else if (c == "\"" || c == "'") begin
					h.st.delim = c; h.st.mode = stu_pkg::M_STR;
				end else if (stu_pkg::is_alpha(c) || c == "_") begin
					h.st = word_add(word_start(s), c); h.st.mode = stu_pkg::M_NAME;
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c);
				end else if (c == ".") begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c); h.st.mode = stu_pkg::M_DOT;
				end else if (stu_pkg::is_digit(c)) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c); h.st.mode = stu_pkg::M_INT;
				end else if (c == "/") h.st.mode = stu_pkg::M_SLASH;
				else begin
					h.n = 2'd2; h.r0 = stu_pkg::mk_text(c); h.r1 = stu_pkg::mk_char(c);
				end
			end
			stu_pkg::M_DOLLAR: begin
				if (stu_pkg::is_word(c)) begin
					h.st = word_add(s, c); h.n = 2'd1; h.r0 = stu_pkg::mk_text(c);
				end else begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1; h.n = 2'd1;
					rr = stu_pkg::mk_fin(stu_pkg::K_DEBUG);
					if (s.dm[0] && s.wlen == stu_pkg::DBG_LEN[0]) rr.debug_on = 1'b1;
					else if (!(s.dm[1] && s.wlen == stu_pkg::DBG_LEN[1]))
						rr = stu_pkg::mk_fin(stu_pkg::K_WRONG);
					h.r0 = rr;
				end
			end
			stu_pkg::M_NAME: begin
				if (stu_pkg::is_word(c)) begin
					h.st = word_add(s, c); h.n = 2'd1; h.r0 = stu_pkg::mk_text(c);
				end else begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1; h.n = 2'd1;
					h.r0 = stu_pkg::mk_fin(stu_pkg::K_NAME);
					for (int k = 15; k >= 0; k--) begin
						if (s.cand[k] && stu_pkg::KW_LEN[k] == s.wlen) begin
							hit = 1'b1;
							h.r0 = stu_pkg::mk_fin(stu_pkg::K_KEYWORD);
							h.r0.keyword_index = 4'(k);
						end
					end
				end
			end
			stu_pkg::M_LT, stu_pkg::M_GT, stu_pkg::M_TILDE: begin
				h.st.mode = stu_pkg::M_IDLE;
				if (c == "=") begin
					h.n = 2'd2; h.r0 = stu_pkg::mk_text(c);
					h.r1 = stu_pkg::mk_fin((s.mode == stu_pkg::M_LT) ? stu_pkg::K_LE :
						(s.mode == stu_pkg::M_GT) ? stu_pkg::K_GE : stu_pkg::K_NE);
				end else begin
					h.n = 2'd1; h.again = 1'b1;
					h.r0 = stu_pkg::mk_char((s.mode == stu_pkg::M_LT) ? 8'h3C :
						(s.mode == stu_pkg::M_GT) ? 8'h3E : 8'h7E);
				end
			end
			stu_pkg::M_DOT: begin
				if (c == ".") begin
					h.n = 2'd2; h.r0 = stu_pkg::mk_text(c);
					h.r1 = stu_pkg::mk_fin(stu_pkg::K_CONC); h.st.mode = stu_pkg::M_IDLE;
				end else if (stu_pkg::is_digit(c)) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c); h.st.mode = stu_pkg::M_FRAC;
				end else begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1; h.n = 2'd1;
					h.r0 = stu_pkg::mk_char(8'h2E);
				end
			end
			stu_pkg::M_STR: begin
				if (c == s.delim) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_fin(stu_pkg::K_STRING);
					h.st.mode = stu_pkg::M_IDLE;
				end else if (c == stu_pkg::CH_NUL || c == stu_pkg::CH_NL) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_fin(stu_pkg::K_WRONG);
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1;
				end else if (c == stu_pkg::CH_BSL) h.st.mode = stu_pkg::M_ESC;
				else begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c);
				end
			end
			stu_pkg::M_ESC: begin
				h.st.mode = stu_pkg::M_STR; h.n = 2'd1;
				if (c == "n") h.r0 = stu_pkg::mk_text(stu_pkg::CH_NL);
				else if (c == "t") h.r0 = stu_pkg::mk_text(stu_pkg::CH_TAB);
				else if (c == "r") h.r0 = stu_pkg::mk_text(stu_pkg::CH_CR);
				else begin
					h.r0 = stu_pkg::mk_text(stu_pkg::CH_BSL); h.again = 1'b1;
				end
			end
			stu_pkg::M_INT, stu_pkg::M_FRAC: begin
				if (stu_pkg::is_digit(c)) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c);
				end else if (c == "." && s.mode == stu_pkg::M_INT) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c); h.st.mode = stu_pkg::M_FRAC;
				end else if (c == "e" || c == "E") begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c); h.st.mode = stu_pkg::M_EXPS;
				end else begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1; h.n = 2'd1;
					h.r0 = stu_pkg::mk_fin(stu_pkg::K_NUMBER);
				end
			end
			stu_pkg::M_EXPS, stu_pkg::M_EXPSIGN: begin
				if (stu_pkg::is_digit(c)) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c); h.st.mode = stu_pkg::M_EXPD;
				end else if (s.mode == stu_pkg::M_EXPS && (c == "+" || c == "-")) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c); h.st.mode = stu_pkg::M_EXPSIGN;
				end else begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1; h.n = 2'd1;
					h.r0 = stu_pkg::mk_fin(stu_pkg::K_WRONG);
				end
			end
			stu_pkg::M_EXPD: begin
				if (stu_pkg::is_digit(c)) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_text(c);
				end else begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1; h.n = 2'd1;
					h.r0 = stu_pkg::mk_fin(stu_pkg::K_NUMBER);
				end
			end
			stu_pkg::M_SLASH: begin
				if (c == "/") h.st.mode = stu_pkg::M_LCOM;
				else if (c == "*") h.st.mode = stu_pkg::M_BCOM;
				else begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1; h.n = 2'd2;
					h.r0 = stu_pkg::mk_text(8'h2F); h.r1 = stu_pkg::mk_char(8'h2F);
				end
			end
			stu_pkg::M_LCOM: begin
				if (c == stu_pkg::CH_NL || c == stu_pkg::CH_NUL) begin
					h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1;
				end
			end
			stu_pkg::M_BCOM, stu_pkg::M_BSTAR: begin
				if (c == stu_pkg::CH_NUL) begin
					h.n = 2'd1; h.r0 = stu_pkg::mk_fin(stu_pkg::K_END);
					h.r0.comment_error = 1'b1;
					h.st.line = fl; h.st.mode = stu_pkg::M_IDLE;
				end else begin
					if (c == stu_pkg::CH_NL) h.st.line = bump(s.line);
					if (s.mode == stu_pkg::M_BSTAR && c == "/") h.st.mode = stu_pkg::M_IDLE;
					else h.st.mode = (c == "*") ? stu_pkg::M_BSTAR : stu_pkg::M_BCOM;
				end
			end
			default: begin
				h.st.mode = stu_pkg::M_IDLE; h.again = 1'b1;
			end
		endcase
		if (hit) h.again = 1'b1;
		return h;
	endfunction

	// Up to four passes over one character; every result carries the line
	// count seen at the start, since counts change only after the last result.
	always_comb begin
		stu_pkg::scan_t s;
		stu_pkg::step_t h;
		logic           go;
		logic [2:0]     n;
		s = st_q;
		go = 1'b1;
		n = '0;
		grp = '0;
		grp.line = st_q.line;
		for (int p = 0; p < stu_pkg::MAX_RES; p++) begin
			if (go) begin
				h = handle(s, src.ch, first_line_q);
				if (h.n != 2'd0 && n < 3'd4) begin
					grp.rec[n[1:0]] = h.r0;
					n = n + 3'd1;
				end
				if (h.n == 2'd2 && n < 3'd4) begin
					grp.rec[n[1:0]] = h.r1;
					n = n + 3'd1;
				end
				s = h.st;
				go = h.again;
			end
		end
		grp.cnt = n;
		st_d = s;
	end

	assign src.ready = !q_full;
	assign push = src.valid && src.ready && grp.cnt != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_line_q <= stu_pkg::LINE_RESET;
			st_q.mode    <= stu_pkg::M_IDLE;
			st_q.cand    <= '1;
			st_q.wlen    <= '0;
			st_q.dm      <= '0;
			st_q.delim   <= '0;
			st_q.line    <= stu_pkg::LINE_RESET;
		end else if (first_line_we) begin
			first_line_q <= first_line_wdata;
			st_q.line    <= first_line_wdata;
		end else if (src.valid && src.ready) begin
			st_q <= st_d;
		end
	end

endmodule

FILE: hw/rtl/stu_queue.sv
// Short queue of result groups between the front and back ends.
// Depends on stu_pkg for the group type.
module stu_queue #(
	parameter int DEPTH = stu_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stu_pkg::group_t wdata,
	output logic            full,
	input  logic            pop,
	output logic            nonempty,
	output stu_pkg::group_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	stu_pkg::group_t      mem_q [DEPTH];
	logic [PW-1:0]        wr_q, rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;

	assign full = cnt_q == ($clog2(DEPTH+1))'(DEPTH);
	assign nonempty = cnt_q != '0;
	assign head = mem_q[rd_q];

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wrap_inc(wr_q);
			if (pop) rd_q <= wrap_inc(rd_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && !nonempty))
		else $error("queue read while empty");

endmodule

FILE: hw/rtl/stu_back.sv
// Back end: sends the results of the head group one beat at a time and marks
// the final one. Depends on stu_pkg and stu_tok_if.
module stu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            nonempty,
	input  stu_pkg::group_t head,
	output logic            pop,
	stu_tok_if.source       tok
);

	logic [1:0]    idx_q;
	stu_pkg::rec_t r;
	logic          at_end;

	assign r = head.rec[idx_q];
	assign at_end = {1'b0, idx_q} == head.cnt - 3'd1;

	assign tok.valid         = nonempty;
	assign tok.is_text       = r.is_text;
	assign tok.text_byte     = r.text_byte;
	assign tok.token_kind    = r.token_kind;
	assign tok.keyword_index = r.keyword_index;
	assign tok.char_value    = r.char_value;
	assign tok.debug_on      = r.debug_on;
	assign tok.line_number   = head.line;
	assign tok.comment_error = r.comment_error;
	assign tok.last          = at_end;

	assign pop = tok.valid && tok.ready && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (tok.valid && tok.ready) begin
			idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
		end
	end

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		nonempty |-> ({1'b0, idx_q} < head.cnt))
		else $error("result index beyond group size");
	a_idx_resets: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0)
		else $error("result index not cleared after group");

endmodule

FILE: hw/rtl/source_tokenizer_unit.sv
// Source tokenizer: one character per beat in, text-byte and token-end beats out.
// Each character's results are registered in the group queue before they go out as beats.
// Throughput: one character per cycle while the output keeps up; a character
// causing n results occupies the output for n beats, and the group queue
// (QUEUE_DEPTH entries) sets how far the input runs ahead.
// Reset clears the scanner to between tokens and sets line count to LINE_RESET; first_line_we loads first_line_wdata.
module source_tokenizer_unit #(
	parameter int QUEUE_DEPTH = stu_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	stu_char_if.sink                   src,
	stu_tok_if.source                  tok,
	input  logic                       first_line_we,
	input  logic [stu_pkg::LINE_W-1:0] first_line_wdata
);

	stu_pkg::group_t grp, head;
	logic            push, full, pop, nonempty;

	stu_front u_front (
		.clk, .arst_n, .src, .first_line_we, .first_line_wdata,
		.q_full(full), .push, .grp
	);

	stu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .wdata(grp), .full, .pop, .nonempty, .head
	);

	stu_back u_back (
		.clk, .arst_n, .nonempty, .head, .pop, .tok
	);

endmodule
